FILE: sv/bapr_pkg.sv
package bapr_pkg;

  // input operation codes
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_RENDER = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // screen store layout
  localparam int unsigned STORE_SIZE   = 6912;
  localparam int unsigned STORE_AW     = $clog2(STORE_SIZE);
  localparam int unsigned SCREEN_LINES = 192;
  localparam logic [STORE_AW-1:0] ATTR_BASE = STORE_AW'(6144);

  // default border offsets
  localparam int unsigned BORDER_LEFT_DEF = 8;
  localparam int unsigned BORDER_TOP_DEF  = 8;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // channel levels of the two palettes
  localparam logic [7:0] LEVEL_NORMAL = 8'hD7;
  localparam logic [7:0] LEVEL_BRIGHT = 8'hFF;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_RENDER,
    KIND_TICK
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [STORE_AW-1:0]  address;
    logic [7:0]           data;
    logic [4:0]           column;
    logic [7:0]           line;
    logic                 flash_only;
  } item_t;

  // colour index bit 0 blue, bit 1 red, bit 2 green
  function automatic logic [23:0] palette(input logic [2:0] idx, input logic bright);
    logic [7:0] level;
    level = bright ? LEVEL_BRIGHT : LEVEL_NORMAL;
    return {idx[1] ? level : 8'h00, idx[2] ? level : 8'h00, idx[0] ? level : 8'h00};
  endfunction

endpackage

FILE: sv/bapr_front.sv
module bapr_front
  import bapr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [12:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic [4:0]  in_column,
  input  logic [7:0]  in_line,
  input  logic        in_flash_only,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  item_t          entry_r [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;
  logic           accept, keep, push;
  item_t          item;

  assign busy   = (count_r == CW'(QUEUE_DEPTH));
  assign accept = start && !busy;

  // classify: out-of-range writes, off-screen lines and unknown codes are dropped
  always_comb begin
    item.address    = in_address;
    item.data       = in_write_data;
    item.column     = in_column;
    item.line       = in_line;
    item.flash_only = in_flash_only;
    item.kind       = KIND_TICK;
    keep            = 1'b0;
    case (in_operation)
      OP_WRITE: begin
        item.kind = KIND_WRITE;
        keep      = (in_address < STORE_AW'(STORE_SIZE));
      end
      OP_RENDER: begin
        item.kind = KIND_RENDER;
        keep      = (in_line < 8'(SCREEN_LINES));
      end
      OP_TICK: begin
        item.kind = KIND_TICK;
        keep      = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push    = accept && keep;
  assign q_valid = (count_r != '0);
  assign q_item  = entry_r[rd_ptr_r];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (q_pop) rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !q_pop) count_r <= count_r + 1'b1;
      else if (!push && q_pop) count_r <= count_r - 1'b1;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH)) else $error("queue count overrun");

endmodule

FILE: sv/bapr_back.sv
module bapr_back
  import bapr_pkg::*;
#(
  parameter int unsigned BORDER_LEFT = BORDER_LEFT_DEF,
  parameter int unsigned BORDER_TOP  = BORDER_TOP_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_valid,
  output logic [8:0]  out_pixel_x,
  output logic [7:0]  out_pixel_y,
  output logic [23:0] out_colour,
  output logic        out_last_pixel
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ATTR,
    ST_BMP,
    ST_PIX
  } state_t;

  logic [7:0]          mem [STORE_SIZE];
  logic [7:0]          rd_data_r;
  logic [STORE_AW-1:0] rd_addr;
  logic                mem_we;

  state_t        state_r;
  logic          phase_r;
  logic [4:0]    col_r;
  logic [7:0]    line_r;
  logic          only_r;
  logic [8:0]    base_x_r;
  logic [23:0]   ink_r, paper_r;
  logic [7:0]    bits_r;
  logic [2:0]    cnt_r;
  logic          out_valid_r, out_last_r;
  logic [8:0]    out_x_r;
  logic [7:0]    out_y_r;
  logic [23:0]   out_colour_r;

  logic [7:0]          attr;
  logic                swap, skip;
  logic [STORE_AW-1:0] attr_addr, bmp_addr;

  assign q_pop  = (state_r == ST_IDLE) && q_valid;
  assign mem_we = q_pop && (q_item.kind == KIND_WRITE);

  // attribute row from line / 8, bitmap in the interleaved thirds layout
  assign attr_addr = ATTR_BASE + STORE_AW'({q_item.line[7:3], q_item.column});
  assign bmp_addr  = {line_r[7:6], line_r[2:0], line_r[5:3], col_r};
  assign rd_addr   = (state_r == ST_ATTR) ? bmp_addr : attr_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_item.address] <= q_item.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign attr = rd_data_r;
  assign swap = attr[7] && phase_r;
  assign skip = only_r && !attr[7];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (q_pop) begin
            col_r    <= q_item.column;
            line_r   <= q_item.line;
            only_r   <= q_item.flash_only;
            base_x_r <= 9'(BORDER_LEFT) + {1'b0, q_item.column, 3'b000};
            out_y_r  <= 8'(BORDER_TOP) + q_item.line;
            case (q_item.kind)
              KIND_RENDER: state_r <= ST_ATTR;
              KIND_TICK:   phase_r <= !phase_r;
              default:     state_r <= ST_IDLE;
            endcase
          end
        end
        ST_ATTR: begin
          ink_r   <= palette(swap ? attr[5:3] : attr[2:0], attr[6]);
          paper_r <= palette(swap ? attr[2:0] : attr[5:3], attr[6]);
          state_r <= skip ? ST_IDLE : ST_BMP;
        end
        ST_BMP: begin
          bits_r  <= rd_data_r;
          cnt_r   <= '0;
          state_r <= ST_PIX;
        end
        ST_PIX: begin
          out_valid_r  <= 1'b1;
          out_x_r      <= base_x_r + 9'(cnt_r);
          out_colour_r <= bits_r[7] ? ink_r : paper_r;
          out_last_r   <= (cnt_r == 3'd7);
          bits_r       <= {bits_r[6:0], 1'b0};
          cnt_r        <= cnt_r + 1'b1;
          if (cnt_r == 3'd7) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_x    = out_x_r;
  assign out_pixel_y    = out_y_r;
  assign out_colour     = out_colour_r;
  assign out_last_pixel = out_last_r;

  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_r |-> out_valid_r) else $error("last pixel without strobe");
  a_gap_after_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_r |=> !out_valid_r) else $error("strobe directly after last pixel");
  a_x_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |=> (out_valid_r && out_x_r == $past(out_x_r) + 9'd1))
    else $error("pixel run broken");

endmodule

FILE: sv/bitmap_attribute_pixel_render.sv
// Bitmap-plus-attribute pixel renderer. A command word is taken when start is
// high and busy is low: operation 0 writes one byte of the 6912-byte screen
// store, 1 renders one character cell row (column, line), 2 toggles the flash
// phase; writes beyond the store, lines of 192 or more and operation 3 are
// dropped. A render gives eight pixel words, leftmost first, each shown for
// exactly one cycle with out_valid high; the receiver cannot stall, so every
// strobed word must be taken. Words of one cell come on consecutive
// cycles, out_last_pixel marks the eighth. A cell whose attribute lacks flash
// gives nothing when in_flash_only is set. A two-entry command queue
// decouples the input from the executing back end, so a new command can be
// taken while a cell is still being drawn until that queue is full. The back
// end does a write or tick in its idle state as it pops it; a skipped cell
// ends after the attribute read, and a drawn cell runs attribute read, bitmap
// read and eight pixels, as the single read port of the screen store
// serialises the two reads. It takes no new command while a render is in
// progress. Reading a never-written store byte gives undefined pixels.
module bitmap_attribute_pixel_render
  import bapr_pkg::*;
#(
  parameter int unsigned BORDER_LEFT = BORDER_LEFT_DEF,
  parameter int unsigned BORDER_TOP  = BORDER_TOP_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [12:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic [4:0]  in_column,
  input  logic [7:0]  in_line,
  input  logic        in_flash_only,
  output logic        out_valid,
  output logic [8:0]  out_pixel_x,
  output logic [7:0]  out_pixel_y,
  output logic [23:0] out_colour,
  output logic        out_last_pixel
);

  // classified command word handed from front to back
  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  // front: classification and command queue
  bapr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .in_column     (in_column),
    .in_line       (in_line),
    .in_flash_only (in_flash_only),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  // back: screen store, flash phase, cell sequencer and pixel output
  bapr_back #(
    .BORDER_LEFT (BORDER_LEFT),
    .BORDER_TOP  (BORDER_TOP)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_colour     (out_colour),
    .out_last_pixel (out_last_pixel)
  );

endmodule
